@@ hw/rtl/btbp_pkg.sv @@
// ----------------------------------------------------------------------------
// btbp_pkg
// Types and fixed constants shared by the branch predictor core.
// ----------------------------------------------------------------------------
`default_nettype none

package btbp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 5;
    localparam logic [1:0]  CNT_WNT     = 2'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BTB_INDEX_BITS  = 3'd0,
        CFG_HISTORY_LENGTH  = 3'd1,
        CFG_TAG_LENGTH      = 3'd2,
        CFG_HISTORY_GLOBAL  = 3'd3,
        CFG_TABLE_GLOBAL    = 3'd4,
        CFG_SHARE_MODE      = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LOW  = 2'd1,
        SHARE_HIGH = 2'd2
    } share_mode_t;

    typedef enum logic {
        FUNC_PREDICT = 1'b0,
        FUNC_UPDATE  = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [31:0] pc;
        logic [31:0] target_pc;
        logic        taken;
        logic [31:0] predicted_dst;
    } req_t;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predicted_target;
        logic        flush_needed;
        logic [31:0] flush_total;
        logic [31:0] branch_total;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/btbp_ram.sv @@
// ----------------------------------------------------------------------------
// btbp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/btb_two_level_branch_predictor_core.sv @@
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_core
// Direct-mapped BTB with a two-level predictor of 2-bit saturating counters.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A predict or an update has these steps:
// accept and BTB read, counter read, then counter data and result (written back
// to both memories in that same cycle). An update that misses on the tag with
// per-entry counter tables first clears that entry's table through the single
// counter RAM write port. After reset the counter RAM and BTB RAM are
// initialised one word per cycle with req_ready low; configuration writes are
// taken throughout. A finished result sits in the output register while the
// next request is accepted.
`default_nettype none

module btb_two_level_branch_predictor_core #(
    parameter int unsigned MAX_BTB_ENTRIES  = 32,
    parameter int unsigned MAX_HISTORY_BITS = 8,
    parameter int unsigned MAX_TAG_BITS     = 30
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire btbp_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output btbp_pkg::rsp_t                    rsp,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [btbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [btbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import btbp_pkg::*;

    localparam int unsigned EW        = (MAX_BTB_ENTRIES > 1) ? $clog2(MAX_BTB_ENTRIES) : 1;
    localparam int unsigned IDX_SAT   = $clog2(MAX_BTB_ENTRIES);
    localparam int unsigned HB        = MAX_HISTORY_BITS;
    localparam int unsigned TW        = MAX_TAG_BITS;
    localparam int unsigned RW        = $clog2(MAX_BTB_ENTRIES + 1);
    localparam int unsigned TBL       = 1 << HB;
    localparam int unsigned CTR_DEPTH = (MAX_BTB_ENTRIES + 1) * TBL;
    localparam int unsigned AW        = RW + HB;
    localparam int unsigned BW        = TW + 32 + HB;

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_LOOK = 6'b000100,
        ST_CLR  = 6'b001000,
        ST_RD   = 6'b010000,
        ST_CTR  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;

    logic [2:0]  btb_bits_reg;
    logic [3:0]  hist_len_reg;
    logic [4:0]  tag_len_reg;
    logic        hist_glb_reg;
    logic        tbl_glb_reg;
    logic [1:0]  share_reg;

    req_t        item_reg;
    logic [EW-1:0] entry_reg;
    logic [TW-1:0] tag_reg;
    logic        miss_reg;
    logic [31:0] tgt_store_reg;
    logic [HB-1:0] btb_hist_reg;
    logic [HB-1:0] hist_used_reg;
    logic [AW-1:0] ctr_addr_reg;
    logic [HB-1:0] clr_cnt_reg;
    logic [AW-1:0] init_cnt_reg;
    logic [HB-1:0] shared_hist_reg;
    logic [31:0] flush_cnt_reg;
    logic [31:0] branch_cnt_reg;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;

    logic        accept;
    logic        finish;
    logic [EW-1:0] entry_in;
    logic [TW-1:0] tag_in;
    logic [HB-1:0] hmask;
    logic [BW-1:0] btb_rdata;
    logic [TW-1:0] r_tag;
    logic [31:0] r_tgt;
    logic [HB-1:0] r_hist;
    logic        look_miss;
    logic [HB-1:0] look_hist;
    logic [HB-1:0] look_idx;
    logic [AW-1:0] look_addr;
    logic [1:0]  ctr_rdata;
    logic [1:0]  ctr_new;
    logic        flush;
    logic [HB-1:0] hist_shift;

    logic        btb_we;
    logic [EW-1:0] btb_waddr;
    logic [BW-1:0] btb_wdata;
    logic        ctr_we;
    logic [AW-1:0] ctr_waddr;
    logic [1:0]  ctr_wdata;
    logic        ctr_re;
    logic [AW-1:0] ctr_raddr;

    // ---- combinational decode of configuration and request PC ----
    always_comb
    begin
        logic [2:0]  bits;
        logic [31:0] m;
        logic [EW:0] raw;
        logic [4:0]  tl;
        logic [31:0] tmask;
        logic [3:0]  hl;
        logic [HB:0] hm;
        bits = (btb_bits_reg > 3'(IDX_SAT)) ? 3'(IDX_SAT) : btb_bits_reg;
        m    = (req.pc >> 2) & ((32'd1 << bits) - 32'd1);
        raw  = {1'b0, m[EW-1:0]};
        if (raw >= (EW+1)'(MAX_BTB_ENTRIES))
        begin
            raw = raw - (EW+1)'(MAX_BTB_ENTRIES);
        end
        entry_in = raw[EW-1:0];
        tl     = (tag_len_reg > 5'(TW)) ? 5'(TW) : tag_len_reg;
        tmask  = (32'd1 << tl) - 32'd1;
        tag_in = TW'((req.pc >> 2) & tmask);
        if (hist_len_reg == 4'd0)
        begin
            hl = 4'd1;
        end
        else if (hist_len_reg > 4'(HB))
        begin
            hl = 4'(HB);
        end
        else
        begin
            hl = hist_len_reg;
        end
        hm    = ((HB+1)'(1) << hl) - (HB+1)'(1);
        hmask = hm[HB-1:0];
    end

    assign r_tag  = btb_rdata[BW-1 -: TW];
    assign r_tgt  = btb_rdata[HB +: 32];
    assign r_hist = btb_rdata[HB-1:0];

    always_comb
    begin
        logic [HB-1:0] x;
        logic [RW-1:0] row;
        look_miss = (tag_reg != r_tag);
        if (hist_glb_reg)
        begin
            look_hist = shared_hist_reg;
        end
        else if (item_reg.func == FUNC_UPDATE && look_miss)
        begin
            look_hist = '0;
        end
        else
        begin
            look_hist = r_hist;
        end
        x = '0;
        if (tbl_glb_reg)
        begin
            case (share_reg)
                SHARE_NONE: x = '0;
                SHARE_LOW:  x = item_reg.pc[2 +: HB];
                default:    x = item_reg.pc[16 +: HB];
            endcase
        end
        look_idx  = (look_hist ^ x) & hmask;
        row       = tbl_glb_reg ? RW'(MAX_BTB_ENTRIES) : RW'(entry_reg);
        look_addr = {row, look_idx};
    end

    assign accept    = req_valid && req_ready;
    assign finish    = (state_reg == ST_CTR) && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- result ----
    always_comb
    begin
        logic tk;
        tk = item_reg.taken;
        if (miss_reg)
        begin
            flush = tk;
        end
        else
        begin
            flush = (ctr_rdata < 2'd2 && tk) || (ctr_rdata >= 2'd2 && !tk)
                 || (tk && item_reg.target_pc != item_reg.predicted_dst);
        end
        if (tk && ctr_rdata != 2'd3)
        begin
            ctr_new = ctr_rdata + 2'd1;
        end
        else if (!tk && ctr_rdata != 2'd0)
        begin
            ctr_new = ctr_rdata - 2'd1;
        end
        else
        begin
            ctr_new = ctr_rdata;
        end
        hist_shift = HB'({hist_used_reg, tk}) & hmask;
    end

    // ---- memory ports ----
    always_comb
    begin
        btb_we    = 1'b0;
        btb_waddr = entry_reg;
        btb_wdata = {tag_reg, item_reg.target_pc,
                     hist_glb_reg ? btb_hist_reg : hist_shift};
        ctr_we    = 1'b0;
        ctr_waddr = ctr_addr_reg;
        ctr_wdata = ctr_new;
        ctr_re    = 1'b0;
        ctr_raddr = look_addr;
        case (state_reg)
            ST_INIT:
            begin
                ctr_we    = 1'b1;
                ctr_waddr = init_cnt_reg;
                ctr_wdata = CNT_WNT;
                btb_we    = (init_cnt_reg < AW'(MAX_BTB_ENTRIES));
                btb_waddr = init_cnt_reg[EW-1:0];
                btb_wdata = '0;
            end
            ST_LOOK:
            begin
                ctr_re = !(item_reg.func == FUNC_UPDATE && look_miss && !tbl_glb_reg);
            end
            ST_CLR:
            begin
                ctr_we    = 1'b1;
                ctr_waddr = {RW'(entry_reg), clr_cnt_reg};
                ctr_wdata = CNT_WNT;
            end
            ST_RD:
            begin
                ctr_re    = 1'b1;
                ctr_raddr = ctr_addr_reg;
            end
            ST_CTR:
            begin
                ctr_we = finish && (item_reg.func == FUNC_UPDATE);
                btb_we = finish && (item_reg.func == FUNC_UPDATE);
            end
            default:
            begin
            end
        endcase
    end

    btbp_ram #(.WIDTH(BW), .DEPTH(MAX_BTB_ENTRIES)) u_btb_ram (
        .clk     (clk),
        .wr_en   (btb_we),
        .wr_addr (btb_waddr),
        .wr_data (btb_wdata),
        .rd_en   (accept),
        .rd_addr (entry_in),
        .rd_data (btb_rdata)
    );

    btbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_ctr_ram (
        .clk     (clk),
        .wr_en   (ctr_we),
        .wr_addr (ctr_waddr),
        .wr_data (ctr_wdata),
        .rd_en   (ctr_re),
        .rd_addr (ctr_raddr),
        .rd_data (ctr_rdata)
    );

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: if (init_cnt_reg == AW'(CTR_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ctr_re ? ST_CTR : ST_CLR;
            ST_CLR:  if (clr_cnt_reg == HB'(TBL - 1)) state_next = ST_RD;
            ST_RD:   state_next = ST_CTR;
            ST_CTR:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            init_cnt_reg    <= '0;
            clr_cnt_reg     <= '0;
            shared_hist_reg <= '0;
            flush_cnt_reg   <= '0;
            branch_cnt_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
            btb_bits_reg    <= 3'd0;
            hist_len_reg    <= 4'd1;
            tag_len_reg     <= 5'd0;
            hist_glb_reg    <= 1'b0;
            tbl_glb_reg     <= 1'b0;
            share_reg       <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + AW'(1);
            end
            if (state_reg == ST_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + HB'(1);
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BTB_INDEX_BITS: btb_bits_reg <= cfg_data[2:0];
                    CFG_HISTORY_LENGTH: hist_len_reg <= cfg_data[3:0];
                    CFG_TAG_LENGTH:     tag_len_reg  <= cfg_data[4:0];
                    CFG_HISTORY_GLOBAL: hist_glb_reg <= cfg_data[0];
                    CFG_TABLE_GLOBAL:   tbl_glb_reg  <= cfg_data[0];
                    CFG_SHARE_MODE:     share_reg    <= cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
                if (item_reg.func == FUNC_UPDATE)
                begin
                    branch_cnt_reg <= branch_cnt_reg + 32'd1;
                    flush_cnt_reg  <= flush_cnt_reg + {31'd0, flush};
                    if (hist_glb_reg)
                    begin
                        shared_hist_reg <= hist_shift;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= req;
            entry_reg <= entry_in;
            tag_reg   <= tag_in;
        end
        if (state_reg == ST_LOOK)
        begin
            miss_reg      <= look_miss;
            tgt_store_reg <= r_tgt;
            btb_hist_reg  <= r_hist;
            hist_used_reg <= look_hist;
            ctr_addr_reg  <= look_addr;
        end
        if (finish)
        begin
            if (item_reg.func == FUNC_UPDATE)
            begin
                rsp_reg.predict_taken    <= 1'b0;
                rsp_reg.predicted_target <= 32'd0;
                rsp_reg.flush_needed     <= flush;
                rsp_reg.flush_total      <= flush_cnt_reg + {31'd0, flush};
                rsp_reg.branch_total     <= branch_cnt_reg + 32'd1;
            end
            else
            begin
                rsp_reg.predict_taken    <= !miss_reg && ctr_rdata >= 2'd2;
                rsp_reg.predicted_target <= (!miss_reg && ctr_rdata >= 2'd2)
                                            ? tgt_store_reg : item_reg.pc + 32'd4;
                rsp_reg.flush_needed     <= 1'b0;
                rsp_reg.flush_total      <= flush_cnt_reg;
                rsp_reg.branch_total     <= branch_cnt_reg;
            end
        end
    end

endmodule

`default_nettype wire
